### hw/rtl/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Types, codes and saturating helpers shared by the landing sequence
// controller, its serial multiplier and its checker.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int unsigned QW       = 32;  // Q16.16 word
	localparam int unsigned TW       = 31;  // unsigned time word
	localparam int unsigned FRAC     = 16;
	localparam int unsigned PW       = QW + TW + 1;  // full product width
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DESCENT_SPEED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DESCENT_ACCEL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIME    = 2'd3;

	localparam logic signed [QW-1:0] DESCENT_SPEED_RST   = -32'sd26214;
	localparam logic signed [QW-1:0] DESCENT_ACCEL_RST   = -32'sd13107;
	localparam logic signed [QW-1:0] STILL_THRESHOLD_RST = -32'sd6554;
	localparam logic [TW-1:0]        CONFIRM_TIME_RST    = 31'd65536;

	// 0.7 in unsigned Q15.16, sized as a time word
	localparam logic [TW-1:0] SEVEN_TENTHS = 31'd45875;

	typedef enum logic [2:0] {
		PH_START     = 3'd0,
		PH_PREDESC   = 3'd1,
		PH_DESCEND   = 3'd2,
		PH_UNCONFIRM = 3'd3,
		PH_GROUND    = 3'd4,
		PH_DISARMED  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DISPATCH,
		SQ_LAUNCH,
		SQ_MUL,
		SQ_APPLY,
		SQ_PUSH
	} seq_t;

	typedef enum logic [1:0] {
		OP_VEL,
		OP_POS,
		OP_LIM
	} op_t;

	typedef struct packed {
		logic                 mode_accepted;
		logic                 guided_active;
		logic                 motors_armed;
		logic signed [QW-1:0] pos_x;
		logic signed [QW-1:0] pos_y;
		logic signed [QW-1:0] pos_z;
		logic signed [QW-1:0] heading;
		logic signed [QW-1:0] meas_vel_z;
		logic [TW-1:0]        elapsed;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           stage;
		logic                 traj_valid;
		logic signed [QW-1:0] target_x;
		logic signed [QW-1:0] target_y;
		logic signed [QW-1:0] target_z;
		logic signed [QW-1:0] target_vel_z;
		logic signed [QW-1:0] target_acc_z;
		logic signed [QW-1:0] target_heading;
		logic                 want_guided;
		logic                 want_disarm;
		logic                 finished;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [TW-1:0]        a;
		logic signed [QW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [PW-1:0] prod;
	} mul_rsp_t;

	// floor(p / 2^16), saturated to a Q16.16 word
	function automatic logic signed [QW-1:0] sat_q16(input logic signed [PW-1:0] p);
		logic [PW-1:QW+FRAC-1] top;
		logic signed [QW-1:0]  res;
		top = p[PW-1:QW+FRAC-1];
		if (top == {(PW-QW-FRAC+1){p[PW-1]}}) begin
			res = p[QW+FRAC-1:FRAC];
		end else if (p[PW-1]) begin
			res = {1'b1, {(QW-1){1'b0}}};
		end else begin
			res = {1'b0, {(QW-1){1'b1}}};
		end
		return res;
	endfunction

	function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] x,
		input logic signed [QW-1:0] y);
		logic signed [QW:0]   s;
		logic signed [QW-1:0] res;
		s = {x[QW-1], x} + {y[QW-1], y};
		if (s[QW] == s[QW-1]) begin
			res = s[QW-1:0];
		end else if (s[QW]) begin
			res = {1'b1, {(QW-1){1'b0}}};
		end else begin
			res = {1'b0, {(QW-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

### hw/rtl/lsc_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_serial_mul
// Bit-serial shift-and-add multiplier: unsigned time word by signed Q16.16
// rate, one multiplier bit per cycle, full-width signed product.
// ----------------------------------------------------------------------------
module lsc_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  lsc_pkg::mul_req_t req,
	output lsc_pkg::mul_rsp_t rsp
);
	import lsc_pkg::*;

	localparam int unsigned CW = $clog2(TW);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        count_q;
	logic signed [QW-1:0] mcand_q;
	logic [TW-1:0]        mplier_q;
	logic signed [QW:0]   hi_q;
	logic signed [QW:0]   sum;

	assign sum = hi_q + (mplier_q[0] ? {mcand_q[QW-1], mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == CW'(TW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// low product bits shift in behind the consumed multiplier bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q     <= '0;
			mplier_q <= req.a;
			mcand_q  <= req.b;
		end else if (busy_q) begin
			hi_q     <= {sum[QW], sum[QW:1]};
			mplier_q <= {sum[0], mplier_q[TW-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {hi_q, mplier_q};

endmodule

### hw/rtl/landing_sequence_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landing_sequence_controller
// Six-stage landing sequencer: guided request, pose capture, velocity ramp
// with height integration, touchdown detection and confirm, disarm, done.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      lsc_pkg::in_item_t
// result    out        result_valid / result_ready  lsc_pkg::out_item_t
// cfg       in         cfg_write                    cfg_index, cfg_data
//
// One tick at a time. Start, predescend, ground and disarmed ticks skip the
// bit-serial multiplier; unconfirmed ticks pass through it once, descending
// ticks three times while the velocity ramps and twice once it is at speed.
// A finished result waits in the output register while the next tick is taken;
// a stalled result holds the sequencer before its push only.
// Reset clears the sequencer state, the setpoints and the registers to defaults.
// ----------------------------------------------------------------------------
module landing_sequence_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  lsc_pkg::in_item_t                item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output lsc_pkg::out_item_t               result,
	input  logic                             cfg_write,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsc_pkg::QW-1:0]           cfg_data
);
	import lsc_pkg::*;

	seq_t                 seq_q, seq_d;
	op_t                  op_q;
	phase_t               phase_q;
	in_item_t             item_q;
	out_item_t            result_q;
	logic                 result_valid_q;

	logic signed [QW-1:0] descent_speed_q;
	logic signed [QW-1:0] descent_accel_q;
	logic signed [QW-1:0] still_threshold_q;
	logic [TW-1:0]        confirm_time_q;

	logic signed [QW-1:0] set_pos_x_q, set_pos_y_q, set_pos_z_q;
	logic signed [QW-1:0] set_vel_z_q, set_acc_z_q, set_heading_q;
	logic [QW-1:0]        still_time_q;

	logic                 traj_q, wguided_q, wdisarm_q, fin_q;

	mul_req_t             mul_req;
	mul_rsp_t             mul_rsp;
	logic                 push;

	logic signed [QW-1:0] prod_q16;
	logic signed [QW-1:0] vel_sum, pos_sum;
	logic signed [PW-1:0] neg_prod;
	logic signed [QW:0]   lim, vz_ext, thr_ext, nthr_ext, diff;
	logic                 still;
	logic [QW:0]          st_sum;
	logic [QW-1:0]        st_next;

	lsc_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign prod_q16 = sat_q16(mul_rsp.prod);
	assign vel_sum  = sat_add(set_vel_z_q, prod_q16);
	assign pos_sum  = sat_add(set_pos_z_q, prod_q16);

	// limit is floor(-descent_speed * 0.7), always within a signed word
	assign neg_prod = -mul_rsp.prod;
	assign lim      = {neg_prod[QW+FRAC-1], neg_prod[QW+FRAC-1:FRAC]};
	assign vz_ext   = {item_q.meas_vel_z[QW-1], item_q.meas_vel_z};
	assign thr_ext  = {still_threshold_q[QW-1], still_threshold_q};
	assign nthr_ext = -thr_ext;
	assign diff     = vz_ext - {set_vel_z_q[QW-1], set_vel_z_q};
	assign still    = (vz_ext > thr_ext) && (vz_ext < nthr_ext) && (diff > lim);

	assign st_sum  = {1'b0, still_time_q} + {{(QW-TW+1){1'b0}}, item_q.elapsed};
	assign st_next = st_sum[QW] ? {QW{1'b1}} : st_sum[QW-1:0];

	// next state
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SQ_IDLE: begin
				if (item_valid) seq_d = SQ_DISPATCH;
			end
			SQ_DISPATCH: begin
				if (phase_q == PH_DESCEND || phase_q == PH_UNCONFIRM) begin
					seq_d = SQ_LAUNCH;
				end else begin
					seq_d = SQ_PUSH;
				end
			end
			SQ_LAUNCH: seq_d = SQ_MUL;
			SQ_MUL: begin
				if (mul_rsp.done) seq_d = SQ_APPLY;
			end
			SQ_APPLY: begin
				seq_d = (op_q == OP_LIM) ? SQ_PUSH : SQ_LAUNCH;
			end
			SQ_PUSH: begin
				if (!result_valid_q || result_ready) seq_d = SQ_IDLE;
			end
			default: seq_d = SQ_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_ready    = (seq_q == SQ_IDLE);
		push          = (seq_q == SQ_PUSH) && (!result_valid_q || result_ready);
		mul_req.start = (seq_q == SQ_LAUNCH);
		mul_req.a     = (op_q == OP_LIM) ? SEVEN_TENTHS : item_q.elapsed;
		unique case (op_q)
			OP_VEL:  mul_req.b = set_acc_z_q;
			OP_POS:  mul_req.b = set_vel_z_q;
			OP_LIM:  mul_req.b = descent_speed_q;
			default: mul_req.b = descent_speed_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descent_speed_q   <= DESCENT_SPEED_RST;
			descent_accel_q   <= DESCENT_ACCEL_RST;
			still_threshold_q <= STILL_THRESHOLD_RST;
			confirm_time_q    <= CONFIRM_TIME_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DESCENT_SPEED:   descent_speed_q   <= cfg_data;
				REG_DESCENT_ACCEL:   descent_accel_q   <= cfg_data;
				REG_STILL_THRESHOLD: still_threshold_q <= cfg_data;
				REG_CONFIRM_TIME:    confirm_time_q    <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q          <= OP_VEL;
			phase_q       <= PH_START;
			set_pos_x_q   <= '0;
			set_pos_y_q   <= '0;
			set_pos_z_q   <= '0;
			set_vel_z_q   <= '0;
			set_acc_z_q   <= '0;
			set_heading_q <= '0;
			still_time_q  <= '0;
			traj_q        <= 1'b0;
			wguided_q     <= 1'b0;
			wdisarm_q     <= 1'b0;
			fin_q         <= 1'b0;
		end else begin
			unique case (seq_q)
				SQ_IDLE: begin
					traj_q    <= 1'b0;
					wguided_q <= 1'b0;
					wdisarm_q <= 1'b0;
					fin_q     <= 1'b0;
				end
				SQ_DISPATCH: begin
					unique case (phase_q)
						PH_START: begin
							wguided_q <= 1'b1;
							if (item_q.mode_accepted) phase_q <= PH_PREDESC;
						end
						PH_PREDESC: begin
							set_pos_x_q   <= item_q.pos_x;
							set_pos_y_q   <= item_q.pos_y;
							set_pos_z_q   <= item_q.pos_z;
							set_vel_z_q   <= '0;
							set_acc_z_q   <= descent_accel_q;
							set_heading_q <= item_q.heading;
							phase_q <= item_q.guided_active ? PH_DESCEND : PH_START;
						end
						PH_DESCEND: begin
							traj_q <= 1'b1;
							if (set_vel_z_q > descent_speed_q) begin
								op_q <= OP_VEL;
							end else begin
								op_q        <= OP_POS;
								set_acc_z_q <= '0;
							end
						end
						PH_UNCONFIRM: begin
							still_time_q <= st_next;
							op_q         <= OP_LIM;
						end
						PH_GROUND: begin
							wdisarm_q <= 1'b1;
							if (!item_q.motors_armed) phase_q <= PH_DISARMED;
						end
						PH_DISARMED: begin
							fin_q <= 1'b1;
						end
						default: phase_q <= PH_START;
					endcase
				end
				SQ_APPLY: begin
					unique case (op_q)
						OP_VEL: begin
							set_vel_z_q <= vel_sum;
							op_q        <= OP_POS;
						end
						OP_POS: begin
							set_pos_z_q <= pos_sum;
							op_q        <= OP_LIM;
						end
						default: begin
							if (phase_q == PH_DESCEND && still) begin
								still_time_q <= '0;
								phase_q      <= PH_UNCONFIRM;
							end else if (phase_q == PH_UNCONFIRM && still &&
								still_time_q > {1'b0, confirm_time_q}) begin
								phase_q <= PH_GROUND;
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			result_q.stage          <= phase_q;
			result_q.traj_valid     <= traj_q;
			result_q.target_x       <= set_pos_x_q;
			result_q.target_y       <= set_pos_y_q;
			result_q.target_z       <= set_pos_z_q;
			result_q.target_vel_z   <= set_vel_z_q;
			result_q.target_acc_z   <= set_acc_z_q;
			result_q.target_heading <= set_heading_q;
			result_q.want_guided    <= wguided_q;
			result_q.want_disarm    <= wdisarm_q;
			result_q.finished       <= fin_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### hw/rtl/lsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks of the landing sequence controller, bound to the top.
// ----------------------------------------------------------------------------
module lsc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input lsc_pkg::out_item_t    result
);
	import lsc_pkg::*;

	// a stalled transfer holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one tick in flight: no transfer in the cycle after an accepted item
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in flight");

	a_guided_stage: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.want_guided |->
			(result.stage == PH_START || result.stage == PH_PREDESC) &&
			!result.traj_valid && !result.want_disarm && !result.finished)
		else $error("guided request outside the start stage");

	a_traj_stage: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.traj_valid |->
			result.stage == PH_DESCEND || result.stage == PH_UNCONFIRM)
		else $error("setpoint issued outside descent");

	a_finished_stage: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.finished || result.want_disarm) |->
			result.stage == PH_GROUND || result.stage == PH_DISARMED)
		else $error("disarm or done before touchdown");

endmodule

bind landing_sequence_controller lsc_checker u_lsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### test/landing_sequence_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landing_sequence_controller_test
// Drives one full landing through the sequencer: start and predescend loops
// with pose capture under many register settings, the velocity ramp and
// height integration, touchdown, the confirm wait with still-time
// saturation, disarm and the terminal stage. Every result is checked field
// by field against a cycle-free model of the sequencer kept in step with
// each accepted transfer. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module landing_sequence_controller_test;
	import lsc_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 150;
	localparam longint Q_SEVEN_TENTHS = 45875;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam longint SPAN_MAX = 64'h0000_0000_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [QW-1:0] cfg_data = '0;

	// sequencer model
	phase_t land_stage = PH_START;
	logic signed [31:0] sp_x = '0;
	logic signed [31:0] sp_y = '0;
	logic signed [31:0] sp_z = '0;
	logic signed [31:0] sp_vz = '0;
	logic signed [31:0] sp_az = '0;
	logic signed [31:0] sp_yaw = '0;
	logic [31:0] still_span = '0;
	logic signed [31:0] cf_speed = -32'sd26214;
	logic signed [31:0] cf_accel = -32'sd13107;
	logic signed [31:0] cf_thr = -32'sd6554;
	logic [30:0] cf_confirm = 31'd65536;

	out_item_t sequencer_reports [$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	// stimulus knobs: percentages, the narrow elapsed-time top and the burst count
	int unsigned accept_pct = 50;
	int unsigned guided_pct = 0;
	int unsigned release_pct = 20;
	int unsigned touch_pct = 0;
	int unsigned wide_dt_pct = 25;
	int unsigned dt_top = 1311;
	int unsigned burst_left = 0;

	landing_sequence_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic signed [31:0] clamp_q(input longint v);
		if (v > WORD_MAX) return 32'sh7FFF_FFFF;
		if (v < WORD_MIN) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] scaled(input logic [30:0] dt,
		input logic signed [31:0] rate);
		longint p;
		p = longint'(dt) * longint'(rate);
		return clamp_q(p >>> 16);
	endfunction

	function automatic longint touch_margin();
		return (-longint'(cf_speed) * Q_SEVEN_TENTHS) >>> 16;
	endfunction

	function automatic bit is_still(input logic signed [31:0] v);
		if (!(longint'(v) > longint'(cf_thr) && longint'(v) < -longint'(cf_thr)))
			return 1'b0;
		return (longint'(v) - longint'(sp_vz)) > touch_margin();
	endfunction

	function automatic out_item_t step_landing(input in_item_t t);
		out_item_t r;
		longint sum;
		logic signed [31:0] vz;
		r = '0;
		vz = t.meas_vel_z;
		case (land_stage)
			PH_START: begin
				r.want_guided = 1'b1;
				if (t.mode_accepted)
					land_stage = PH_PREDESC;
			end
			PH_PREDESC: begin
				sp_x = t.pos_x;
				sp_y = t.pos_y;
				sp_z = t.pos_z;
				sp_vz = '0;
				sp_az = cf_accel;
				sp_yaw = t.heading;
				land_stage = t.guided_active ? PH_DESCEND : PH_START;
			end
			PH_DESCEND: begin
				if (sp_vz > cf_speed) begin
					sp_vz = clamp_q(longint'(sp_vz) + longint'(scaled(t.elapsed, sp_az)));
					sp_z = clamp_q(longint'(sp_z) + longint'(scaled(t.elapsed, sp_vz)));
				end else begin
					sp_z = clamp_q(longint'(sp_z) + longint'(scaled(t.elapsed, sp_vz)));
					sp_az = '0;
				end
				r.traj_valid = 1'b1;
				if (is_still(vz)) begin
					still_span = '0;
					land_stage = PH_UNCONFIRM;
				end
			end
			PH_UNCONFIRM: begin
				sum = longint'(still_span) + longint'(t.elapsed);
				still_span = (sum > SPAN_MAX) ? 32'hFFFF_FFFF : sum[31:0];
				if (is_still(vz) && still_span > {1'b0, cf_confirm})
					land_stage = PH_GROUND;
			end
			PH_GROUND: begin
				r.want_disarm = 1'b1;
				if (!t.motors_armed)
					land_stage = PH_DISARMED;
			end
			PH_DISARMED: begin
				r.finished = 1'b1;
			end
			default: begin
				land_stage = PH_START;
			end
		endcase
		r.stage = land_stage;
		r.target_x = sp_x;
		r.target_y = sp_y;
		r.target_z = sp_z;
		r.target_vel_z = sp_vz;
		r.target_acc_z = sp_az;
		r.target_heading = sp_yaw;
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return 32'h7FFF_FFFF;
		if (r < 16) return 32'h8000_0000;
		if (r < 20) return 32'h0;
		return $urandom;
	endfunction

	function automatic logic [31:0] neg_word();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15) return 32'h0;
		if (r < 30) return 32'h8000_0000;
		if (r < 60) return 32'h8000_0000 | ($urandom & 32'h7FFF_FFFF);
		return 32'd0 - $urandom_range(1, 262144);
	endfunction

	function automatic logic [30:0] pick_elapsed();
		int unsigned r;
		logic [31:0] w;
		if ($urandom_range(99) < wide_dt_pct) begin
			r = $urandom_range(3);
			case (r)
				0: w = 32'h0;
				1: w = 32'h7FFF_FFFF;
				2: w = $urandom;
				default: w = $urandom_range(262144);
			endcase
		end else begin
			w = $urandom_range(1, dt_top);
		end
		return w[30:0];
	endfunction

	function automatic logic [31:0] moving_vz();
		longint brink;
		int unsigned r;
		r = $urandom_range(9);
		brink = longint'(sp_vz) + touch_margin();
		if (r == 0) return cf_thr;
		if (r == 1 && cf_thr != 32'sh8000_0000) return -cf_thr;
		if (r == 2 && brink <= WORD_MAX && brink >= WORD_MIN) return brink[31:0];
		return $urandom;
	endfunction

	function automatic logic [31:0] still_vz();
		longint lo;
		longint hi;
		longint v;
		longint unsigned span;
		lo = longint'(sp_vz) + touch_margin() + 1;
		if (lo < longint'(cf_thr) + 1)
			lo = longint'(cf_thr) + 1;
		hi = -longint'(cf_thr) - 1;
		if (lo > hi) return moving_vz();
		span = hi - lo + 1;
		case ($urandom_range(7))
			0: v = lo;
			1: v = hi;
			default: v = lo + longint'({$urandom, $urandom} % span);
		endcase
		return v[31:0];
	endfunction

	function automatic in_item_t make_tick();
		in_item_t t;
		t.mode_accepted = 1'($urandom_range(1));
		t.guided_active = 1'($urandom_range(1));
		t.motors_armed = 1'($urandom_range(1));
		t.pos_x = pick_word();
		t.pos_y = pick_word();
		t.pos_z = pick_word();
		t.heading = pick_word();
		t.meas_vel_z = $urandom;
		t.elapsed = pick_elapsed();
		case (land_stage)
			PH_START: t.mode_accepted = ($urandom_range(99) < accept_pct);
			PH_PREDESC: t.guided_active = ($urandom_range(99) < guided_pct);
			PH_GROUND: t.motors_armed = !($urandom_range(99) < release_pct);
			PH_DESCEND, PH_UNCONFIRM:
				t.meas_vel_z = ($urandom_range(99) < touch_pct) ? still_vz() : moving_vz();
			default: ;
		endcase
		return t;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3) begin
			burst_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, want %h",
				results_seen, name, got, want));
	endtask

	task automatic send_tick(input in_item_t t);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= t;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sequencer_reports.push_back(step_landing(t));
	endtask

	task automatic program_regs(input logic [31:0] speed, input logic [31:0] accel,
		input logic [31:0] thr, input logic [31:0] confirm);
		logic [31:0] vals [4];
		logic [CFG_IDX_W-1:0] order [4];
		vals = '{speed, accel, thr, confirm};
		order = '{REG_DESCENT_SPEED, REG_DESCENT_ACCEL, REG_STILL_THRESHOLD, REG_CONFIRM_TIME};
		item_valid <= 1'b0;
		while (sequencer_reports.size() != 0) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
		end
		@(posedge clk);
		cfg_write <= 1'b0;
		cf_speed = speed;
		cf_accel = accel;
		cf_thr = thr;
		cf_confirm = confirm[30:0];
	endtask

	task automatic test_reset_state();
		in_item_t t;
		t = '0;
		send_tick(t);
		t = '1;
		t.mode_accepted = 1'b0;
		send_tick(t);
		t = '0;
		t.mode_accepted = 1'b1;
		send_tick(t);
		t = '1;
		t.guided_active = 1'b0;
		send_tick(t);
		t = '0;
		t.mode_accepted = 1'b1;
		send_tick(t);
		t = '0;
		t.pos_x = 32'h7FFF_FFFF;
		t.pos_y = 32'h7FFF_FFFF;
		t.pos_z = 32'h7FFF_FFFF;
		t.heading = 32'h8000_0000;
		send_tick(t);
		t = '1;
		send_tick(t);
		t = '0;
		t.pos_x = 32'h8000_0000;
		t.pos_y = 32'h8000_0000;
		t.pos_z = 32'h8000_0000;
		t.heading = 32'h7FFF_FFFF;
		t.motors_armed = 1'b1;
		send_tick(t);
	endtask

	task automatic test_capture_loop();
		accept_pct = 60;
		guided_pct = 0;
		wide_dt_pct = 25;
		for (int chunk = 0; chunk < 14; chunk++) begin
			case (chunk)
				0: program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
				1: program_regs(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
				default: program_regs(neg_word(), neg_word(), neg_word(), $urandom);
			endcase
			repeat (15) send_tick(make_tick());
		end
	endtask

	task automatic test_descent_ramp();
		program_regs(32'd0 - $urandom_range(13107, 65536), 32'd0 - $urandom_range(6554, 65536),
			32'd0 - $urandom_range(3277, 13107), 32'd65536);
		accept_pct = 100;
		guided_pct = 100;
		touch_pct = 0;
		wide_dt_pct = 0;
		dt_top = 1311;
		while (land_stage == PH_START || land_stage == PH_PREDESC)
			send_tick(make_tick());
		repeat (40) if (land_stage == PH_DESCEND) send_tick(make_tick());
		program_regs(32'h8000_0000, cf_accel, 32'h0, {1'b0, cf_confirm});
		wide_dt_pct = 30;
		repeat (20) if (land_stage == PH_DESCEND) send_tick(make_tick());
		program_regs(32'h0, cf_accel, 32'h0, {1'b0, cf_confirm});
		repeat (12) if (land_stage == PH_DESCEND) send_tick(make_tick());
	endtask

	task automatic test_touchdown();
		program_regs(32'd0 - $urandom_range(13107, 65536), cf_accel,
			32'd0 - $urandom_range(6554, 65536), $urandom_range(65536, 131072));
		touch_pct = 25;
		wide_dt_pct = 0;
		dt_top = 1311;
		repeat (40) if (land_stage == PH_DESCEND) send_tick(make_tick());
		if (land_stage == PH_DESCEND) begin
			program_regs(cf_speed, cf_accel, 32'h8000_0000, {1'b0, cf_confirm});
			touch_pct = 100;
			while (land_stage == PH_DESCEND) send_tick(make_tick());
		end
	endtask

	task automatic test_confirm();
		in_item_t t;
		program_regs(cf_speed, cf_accel, 32'd0 - $urandom_range(6554, 65536),
			$urandom_range(65536, 131072));
		touch_pct = 50;
		wide_dt_pct = 0;
		dt_top = 1311;
		repeat (25) if (land_stage == PH_UNCONFIRM) send_tick(make_tick());
		if (land_stage == PH_UNCONFIRM) begin
			// never still: drive the still time into saturation
			program_regs(cf_speed, cf_accel, 32'h0, 32'hFFFF_FFFF);
			repeat (4) begin
				t = make_tick();
				t.elapsed = '1;
				send_tick(t);
			end
			repeat (4) send_tick(make_tick());
			program_regs(cf_speed, cf_accel, 32'h8000_0000, 32'h0);
			touch_pct = 60;
			wide_dt_pct = 20;
			while (land_stage == PH_UNCONFIRM) send_tick(make_tick());
		end
	endtask

	task automatic test_disarm();
		release_pct = 20;
		touch_pct = 30;
		wide_dt_pct = 20;
		while (land_stage == PH_GROUND) send_tick(make_tick());
		repeat (12) send_tick(make_tick());
	endtask

	initial begin : ready_driver
		int unsigned r;
		int unsigned run;
		logic level;
		forever begin
			@(posedge clk);
			r = $urandom_range(99);
			if (r < 50) begin
				level = 1'b1;
				run = $urandom_range(1, 12);
			end else if (r < 60) begin
				level = 1'b1;
				run = $urandom_range(30, 80);
			end else if (r < 90) begin
				level = 1'b0;
				run = $urandom_range(1, 3);
			end else if (r < 97) begin
				level = 1'b0;
				run = $urandom_range(4, 20);
			end else begin
				level = 1'b0;
				run = $urandom_range(40, 150);
			end
			result_ready <= level;
			repeat (run - 1) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (result_valid === 1'b1 && result_ready) begin
			if (sequencer_reports.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing outstanding",
					results_seen));
			end else begin
				want = sequencer_reports.pop_front();
				check_field("stage", 32'(result.stage), 32'(want.stage));
				check_field("traj_valid", 32'(result.traj_valid), 32'(want.traj_valid));
				check_field("target_x", result.target_x, want.target_x);
				check_field("target_y", result.target_y, want.target_y);
				check_field("target_z", result.target_z, want.target_z);
				check_field("target_vel_z", result.target_vel_z, want.target_vel_z);
				check_field("target_acc_z", result.target_acc_z, want.target_acc_z);
				check_field("target_heading", result.target_heading, want.target_heading);
				check_field("want_guided", 32'(result.want_guided), 32'(want.want_guided));
				check_field("want_disarm", 32'(result.want_disarm), 32'(want.want_disarm));
				check_field("finished", 32'(result.finished), 32'(want.finished));
			end
			results_seen++;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL landing_sequence_controller");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_capture_loop();
		test_descent_ramp();
		test_touchdown();
		test_confirm();
		test_disarm();
		item_valid <= 1'b0;
		while (sequencer_reports.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS landing_sequence_controller");
		end else begin
			$display("FAIL landing_sequence_controller");
		end
		$finish;
	end

endmodule
